// ===== design/das_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, status and command codes, and the ring control struct
// for the directed adjacency store. No dependencies.
package das_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int KIDX_W       = $clog2(MAX_DEGREE);
  localparam int DEG_W        = $clog2(MAX_DEGREE + 1);
  localparam int ADDR_W       = VIDX_W + KIDX_W;
  localparam int VERT_W       = 7;
  localparam int WEIGHT_W     = 32;
  localparam int COUNT_W      = 11;
  localparam int STATUS_W     = 3;
  localparam int CMD_W        = 2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOOP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REPEAT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  // commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OUTDG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INDG  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TOTAL = 2'd3;

  // ring control: rotate all cells, or load the head cell
  typedef struct packed {
    logic             rot;
    logic             ld;
    logic [DEG_W-1:0] ld_val;
  } ring_ctl_t;

endpackage

// ===== design/das_cell.sv =====
`timescale 1ns / 1ps
// One ring cell: holds the out-degree of one vertex list.
// Depends on das_pkg.
module das_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic [das_pkg::DEG_W-1:0] nb_i,
  input  logic                     ld_i,
  input  logic [das_pkg::DEG_W-1:0] ld_val_i,
  output logic [das_pkg::DEG_W-1:0] cnt_o
);

  logic [das_pkg::DEG_W-1:0] cnt_q, cnt_d;

  // take neighbor value on shift, new value on load, else hold
  always_comb begin
    cnt_d = cnt_q;
    if (shift_i) begin
      cnt_d = nb_i;
    end else if (ld_i) begin
      cnt_d = ld_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ===== design/das_ring.sv =====
`timescale 1ns / 1ps
// Rotating ring of degree cells with a head pointer that names the vertex
// index sitting in cell 0. Depends on das_pkg and das_cell.
module das_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  das_pkg::ring_ctl_t         ctl_i,
  output logic [das_pkg::DEG_W-1:0]  head_cnt_o,
  output logic [das_pkg::VIDX_W-1:0] head_idx_o
);

  logic [das_pkg::DEG_W-1:0] cnt [das_pkg::MAX_VERTICES];
  logic [das_pkg::VIDX_W-1:0] head_q, head_d;

  // each cell takes from its upper neighbor, the last from cell 0
  for (genvar i = 0; i < das_pkg::MAX_VERTICES; i++) begin : g_cell
    das_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (ctl_i.rot),
      .nb_i     (cnt[(i + 1) % das_pkg::MAX_VERTICES]),
      .ld_i     (ctl_i.ld && (i == 0)),
      .ld_val_i (ctl_i.ld_val),
      .cnt_o    (cnt[i])
    );
  end

  // advance head pointer with each rotation
  assign head_d = ctl_i.rot ? head_q + 1'b1 : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign head_cnt_o = cnt[0];
  assign head_idx_o = head_q;

endmodule

// ===== design/directed_adjacency_store_top.sv =====
`timescale 1ns / 1ps
// Directed adjacency store top: command sequencer, neighbor/weight memories,
// degree ring and APB register. Depends on das_pkg and das_ring.
// One item at a time; a command is taken only while the sequencer is idle.
// The degree ring turns one cell a cycle; the memories give one read a cycle.
// Reset clears all degrees and sets num_vertices to 64; no clearing pass.
module directed_adjacency_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // command[1:0] src_vertex[8:2] dst_vertex[15:9] edge_weight[47:16]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // status[2:0] count[13:3] zero[15:14]
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SEEK     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_INS      = 4'd6;
  localparam logic [3:0] S_NEXT     = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  localparam logic [2:0] REG_NUMV = 3'd0;

  // input field split
  logic [das_pkg::CMD_W-1:0]    in_cmd;
  logic [das_pkg::VERT_W-1:0]   in_src, in_dst;
  logic [das_pkg::WEIGHT_W-1:0] in_w;
  assign in_cmd = s_tdata[1:0];
  assign in_src = s_tdata[8:2];
  assign in_dst = s_tdata[15:9];
  assign in_w   = s_tdata[47:16];

  // configuration register
  logic [das_pkg::VERT_W-1:0] numv_q;
  logic [das_pkg::VERT_W-1:0] act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numv_q <= das_pkg::VERT_W'(das_pkg::MAX_VERTICES);
    end else if (psel && penable && pwrite && (paddr == REG_NUMV)) begin
      numv_q <= pwdata[das_pkg::VERT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_NUMV) ? {25'd0, numv_q} : 32'd0;
  assign act = (numv_q > das_pkg::VERT_W'(das_pkg::MAX_VERTICES)) ?
               das_pkg::VERT_W'(das_pkg::MAX_VERTICES) : numv_q;

  // sequencer registers
  logic [3:0]                   state_q, state_d;
  logic [das_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [das_pkg::VERT_W-1:0]   v_q, v_d;
  logic [das_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic [das_pkg::VIDX_W-1:0]   tgt_q, tgt_d;
  logic [das_pkg::DEG_W-1:0]    k_q, k_d, pos_q, pos_d;
  logic [das_pkg::COUNT_W-1:0]  acc_q, acc_d;
  logic [das_pkg::VIDX_W-1:0]   cnt_q, cnt_d;
  logic [das_pkg::STATUS_W-1:0] res_st_q, res_st_d;

  // output register
  logic                         ov_q, ov_d;
  logic [das_pkg::STATUS_W-1:0] ost_q, ost_d;
  logic [das_pkg::COUNT_W-1:0]  ocnt_q, ocnt_d;

  // ring
  das_pkg::ring_ctl_t         ring_ctl;
  logic [das_pkg::DEG_W-1:0]  deg;
  logic [das_pkg::VIDX_W-1:0] head;

  das_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ring_ctl),
    .head_cnt_o (deg),
    .head_idx_o (head)
  );

  // memories
  logic [das_pkg::VERT_W-1:0]   nb_mem [das_pkg::MAX_VERTICES*das_pkg::MAX_DEGREE];
  logic [das_pkg::WEIGHT_W-1:0] wt_mem [das_pkg::MAX_VERTICES*das_pkg::MAX_DEGREE];
  logic [das_pkg::VERT_W-1:0]   nb_rd_q;
  logic [das_pkg::WEIGHT_W-1:0] wt_rd_q;
  logic                         we;
  logic [das_pkg::ADDR_W-1:0]   wa, ra;
  logic [das_pkg::VERT_W-1:0]   wd_nb;
  logic [das_pkg::WEIGHT_W-1:0] wd_wt;

  always_ff @(posedge clk_i) begin
    if (we) begin
      nb_mem[wa] <= wd_nb;
      wt_mem[wa] <= wd_wt;
    end
    nb_rd_q <= nb_mem[ra];
    wt_rd_q <= wt_mem[ra];
  end

  // input checks
  logic [das_pkg::STATUS_W-1:0] chk;
  always_comb begin
    chk = das_pkg::ST_OK;
    if (in_cmd == das_pkg::CMD_ADD) begin
      if (in_src == '0 || in_dst == '0) begin
        chk = das_pkg::ST_LOW;
      end else if (in_src > act || in_dst > act) begin
        chk = das_pkg::ST_MISSING;
      end else if (in_src == in_dst) begin
        chk = das_pkg::ST_LOOP;
      end
    end else if (in_cmd != das_pkg::CMD_TOTAL) begin
      if (in_src > act) begin
        chk = das_pkg::ST_MISSING;
      end else if (in_src == '0) begin
        chk = das_pkg::ST_LOW;
      end
    end
  end

  logic [das_pkg::VERT_W-1:0] src_m1;
  assign src_m1 = in_src - 1'b1;
  assign s_tready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    v_d      = v_q;
    w_d      = w_q;
    tgt_d    = tgt_q;
    k_d      = k_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    res_st_d = res_st_q;
    ov_d     = ov_q && !m_tready;
    ost_d    = ost_q;
    ocnt_d   = ocnt_q;
    ring_ctl = '0;
    we       = 1'b0;
    wa       = {head, k_q[das_pkg::KIDX_W-1:0]};
    ra       = {head, k_q[das_pkg::KIDX_W-1:0]};
    wd_nb    = nb_rd_q;
    wd_wt    = wt_rd_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_d    = in_cmd;
          v_d      = (in_cmd == das_pkg::CMD_ADD) ? in_dst : in_src;
          w_d      = in_w;
          tgt_d    = (in_cmd == das_pkg::CMD_INDG) ? '0 : src_m1[das_pkg::VIDX_W-1:0];
          acc_d    = '0;
          cnt_d    = '0;
          k_d      = '0;
          res_st_d = chk;
          if (chk != das_pkg::ST_OK) begin
            state_d = S_DONE;
          end else if (in_cmd == das_pkg::CMD_TOTAL) begin
            state_d = S_SUM;
          end else begin
            state_d = S_SEEK;
          end
        end
      end
      S_SEEK: begin
        // rotate the target list into the head cell
        if (head == tgt_q) begin
          k_d   = '0;
          pos_d = deg;
          if (cmd_q == das_pkg::CMD_OUTDG) begin
            acc_d   = das_pkg::COUNT_W'(deg);
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end else begin
          ring_ctl.rot = 1'b1;
        end
      end
      S_SCAN_RD: begin
        if (k_q == deg) begin
          if (cmd_q == das_pkg::CMD_INDG) begin
            state_d = S_NEXT;
          end else if (deg >= das_pkg::DEG_W'(das_pkg::MAX_DEGREE)) begin
            res_st_d = das_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            k_d     = deg;
            state_d = S_SHIFT_RD;
          end
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (cmd_q == das_pkg::CMD_INDG) begin
          if (nb_rd_q == v_q) begin
            acc_d   = acc_q + 1'b1;
            state_d = S_NEXT;
          end else if (nb_rd_q > v_q) begin
            state_d = S_NEXT;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_SCAN_RD;
          end
        end else if (nb_rd_q == v_q) begin
          res_st_d = das_pkg::ST_REPEAT;
          state_d  = S_DONE;
        end else if (v_q < nb_rd_q) begin
          pos_d = k_q;
          if (deg >= das_pkg::DEG_W'(das_pkg::MAX_DEGREE)) begin
            res_st_d = das_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            k_d     = deg;
            state_d = S_SHIFT_RD;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        // read the entry below the slot being opened
        ra = {head, das_pkg::KIDX_W'(k_q - 1'b1)};
        if (k_q == pos_q) begin
          state_d = S_INS;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        k_d     = k_q - 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_INS: begin
        we              = 1'b1;
        wa              = {head, pos_q[das_pkg::KIDX_W-1:0]};
        wd_nb           = v_q;
        wd_wt           = w_q;
        ring_ctl.ld     = 1'b1;
        ring_ctl.ld_val = deg + 1'b1;
        state_d         = S_DONE;
      end
      S_NEXT: begin
        // move on to the next list
        ring_ctl.rot = 1'b1;
        k_d          = '0;
        if (das_pkg::VERT_W'(head) + 1'b1 >= act) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SUM: begin
        // add each active list length as it passes the head
        ring_ctl.rot = 1'b1;
        if (das_pkg::VERT_W'(head) < act) begin
          acc_d = acc_q + das_pkg::COUNT_W'(deg);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || m_tready) begin
          ov_d    = 1'b1;
          ost_d   = res_st_q;
          ocnt_d  = (res_st_q == das_pkg::ST_OK) ? acc_q : '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    v_q      <= v_d;
    w_q      <= w_d;
    tgt_q    <= tgt_d;
    k_q      <= k_d;
    pos_q    <= pos_d;
    acc_q    <= acc_d;
    cnt_q    <= cnt_d;
    res_st_q <= res_st_d;
    ost_q    <= ost_d;
    ocnt_q   <= ocnt_d;
  end

  assign m_tvalid = ov_q;
  assign m_tdata  = {2'b00, ocnt_q, ost_q};

  // insert bumps the head list length by one
  a_ins_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |=> (deg == $past(deg) + 1'b1))
    else $error("insert did not bump degree");

  // ring stays put while a list entry is compared
  a_scan_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CMP) |-> $stable(head))
    else $error("ring moved during scan");

  // a new result only comes out of the done state
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> ($past(state_q) == S_DONE))
    else $error("result without done state");

endmodule
